// ===== hdl/pbbb_pkg.sv =====
// Shared types and constants for the proximity blob bounding box block.
package pbbb_pkg;

	localparam int CoordW = 10;
	localparam int IdxW   = 6;
	localparam int DistW  = 22;
	localparam int SqW    = 24;

	localparam logic [7:0]       ThreshReset = 8'd60;
	localparam logic [DistW-1:0] DistReset   = 22'd64;

	localparam logic CfgThresh = 1'b0;
	localparam logic CfgDist   = 1'b1;

	typedef struct packed {
		logic [7:0]        pixel_value;
		logic [CoordW-1:0] pos_x;
		logic [CoordW-1:0] pos_y;
		logic              frame_end;
	} pix_in_t;

	typedef struct packed {
		logic [IdxW-1:0]   blob_index;
		logic [CoordW-1:0] box_min_x;
		logic [CoordW-1:0] box_min_y;
		logic [CoordW-1:0] box_max_x;
		logic [CoordW-1:0] box_max_y;
		logic              blob_valid;
		logic              table_overflow;
		logic              last_blob;
	} blob_out_t;

	// Word passed from the front to the back part.
	typedef struct packed {
		logic              bright;
		logic [CoordW-1:0] x;
		logic [CoordW-1:0] y;
		logic              frame_end;
	} job_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RD,
		ST_CMP,
		ST_OUT_RD,
		ST_OUT
	} bk_state_t;

endpackage

// ===== hdl/pbbb_front.sv =====
// Front part: classifies pixels and queues jobs for the back part.
module pbbb_front #(
	parameter int FRAME_COLUMNS = 1024,
	parameter int FRAME_ROWS    = 1024
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  pbbb_pkg::pix_in_t in_word,
	input  logic [7:0]       thresh,
	output logic             job_valid,
	input  logic             job_ready,
	output pbbb_pkg::job_t   job
);
	import pbbb_pkg::*;

	localparam int Depth = 4;

	job_t       fifo_q [Depth];
	logic [1:0] wr_q, rd_q;
	logic [2:0] cnt_q;
	job_t       nj;
	logic       push, pop;

	// Classify incoming pixel
	always_comb begin
		nj.x = in_word.pos_x;
		nj.y = in_word.pos_y;
		nj.frame_end = in_word.frame_end;
		nj.bright = (in_word.pixel_value > thresh) &&
			(32'(in_word.pos_x) < FRAME_COLUMNS) && (32'(in_word.pos_y) < FRAME_ROWS);
	end

	assign in_ready  = (cnt_q != 3'(Depth));
	assign push      = in_valid && in_ready;
	assign job_valid = (cnt_q != 3'd0);
	assign pop       = job_valid && job_ready;
	assign job       = fifo_q[rd_q];

	// Short job queue
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 2'd1;
			if (pop) rd_q <= rd_q + 2'd1;
			cnt_q <= cnt_q + 3'(push) - 3'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) fifo_q[wr_q] <= nj;
	end

endmodule

// ===== hdl/pbbb_back.sv =====
// Back part: sequential blob table search, update and frame readout.
module pbbb_back #(
	parameter int MAX_BLOBS = 64
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 job_valid,
	output logic                 job_ready,
	input  pbbb_pkg::job_t       job,
	input  logic [pbbb_pkg::DistW-1:0] dist_lim,
	output logic                 out_valid,
	input  logic                 out_ready,
	output pbbb_pkg::blob_out_t  out_word
);
	import pbbb_pkg::*;

	localparam int AW = (MAX_BLOBS > 1) ? $clog2(MAX_BLOBS) : 1;
	localparam int NW = $clog2(MAX_BLOBS + 1);

	logic [4*CoordW-1:0] mem_q [MAX_BLOBS];
	logic [4*CoordW-1:0] rd_q;
	bk_state_t           st_q, st_d;
	job_t                job_q;
	logic [NW-1:0]       n_q;
	logic [AW-1:0]       i_q;
	logic                drop_q;
	logic                we;
	logic [AW-1:0]       wa;
	logic [4*CoordW-1:0] wd;
	logic [AW-1:0]       ra;
	logic                take, hit, last_i, full;
	logic [CoordW-1:0]   l, t, r, b;
	logic [CoordW:0]     dx, dy;
	logic [SqW-1:0]      d;
	logic [DistW+1:0]    lim;
	blob_out_t           ow_q;
	logic                ov_q;

	assign {l, t, r, b} = rd_q;
	// Doubled-coordinate distance test
	always_comb begin
		logic [CoordW:0] cx, px, cy, py;
		cx = {1'b0, l} + {1'b0, r};
		px = {job_q.x, 1'b0};
		cy = {1'b0, t} + {1'b0, b};
		py = {job_q.y, 1'b0};
		dx = (cx >= px) ? cx - px : px - cx;
		dy = (cy >= py) ? cy - py : py - cy;
		d  = 24'(23'(dx * dx) + 23'(dy * dy));
		lim = {dist_lim, 2'b00};
		hit = (d < lim);
	end

	assign last_i = (NW'(i_q) + NW'(1) == n_q);
	assign full   = (32'(n_q) == MAX_BLOBS);
	assign out_valid = ov_q;
	assign out_word  = ow_q;
	assign take = !ov_q || out_ready;

	// Sequencer
	always_comb begin
		st_d = st_q;
		job_ready = 1'b0;
		we = 1'b0;
		wa = i_q;
		wd = {job_q.x, job_q.y, job_q.x, job_q.y};
		ra = i_q;
		case (st_q)
			ST_IDLE: begin
				job_ready = 1'b1;
				ra = '0;
				if (job_valid) begin
					if (job.bright && n_q != '0) st_d = ST_RD;
					else if (job.bright) st_d = ST_CMP;
					else if (job.frame_end) st_d = ST_OUT_RD;
				end
			end
			ST_RD: st_d = ST_CMP;
			ST_CMP: begin
				if (n_q != '0 && hit) begin
					we = 1'b1;
					wd = {(job_q.x < l) ? job_q.x : l, (job_q.y < t) ? job_q.y : t,
						(job_q.x > r) ? job_q.x : r, (job_q.y > b) ? job_q.y : b};
					st_d = job_q.frame_end ? ST_OUT_RD : ST_IDLE;
				end else if (n_q != '0 && !last_i) begin
					ra = i_q + AW'(1);
					st_d = ST_RD;
				end else begin
					we = !full;
					wa = AW'(n_q);
					st_d = job_q.frame_end ? ST_OUT_RD : ST_IDLE;
				end
			end
			ST_OUT_RD: st_d = ST_OUT;
			ST_OUT: begin
				if (take) begin
					if (n_q == '0 || last_i) st_d = ST_IDLE;
					else begin
						ra = i_q + AW'(1);
						st_d = ST_OUT_RD;
					end
				end
			end
			default: st_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= ST_IDLE;
			n_q    <= '0;
			i_q    <= '0;
			drop_q <= 1'b0;
			ov_q   <= 1'b0;
		end else begin
			st_q <= st_d;
			// output word register loads only in the readout state
			if (take) ov_q <= (st_q == ST_OUT);
			case (st_q)
				ST_IDLE: i_q <= '0;
				ST_CMP: begin
					if (!(n_q != '0 && hit) && n_q != '0 && !last_i) i_q <= i_q + AW'(1);
					else begin
						i_q <= '0;
						if (!(n_q != '0 && hit)) begin
							if (full) drop_q <= 1'b1;
							else n_q <= n_q + NW'(1);
						end
					end
				end
				ST_OUT: begin
					if (take) begin
						if (n_q == '0 || last_i) begin
							n_q <= '0;
							drop_q <= 1'b0;
						end else i_q <= i_q + AW'(1);
					end
				end
				default: ;
			endcase
		end
	end

	// Table memory and result register
	always_ff @(posedge clk) begin
		if (we) mem_q[wa] <= wd;
		rd_q <= mem_q[ra];
		if (st_q == ST_IDLE && job_valid) job_q <= job;
		if (st_q == ST_OUT && take) begin
			ow_q.blob_index     <= IdxW'(i_q);
			ow_q.box_min_x      <= (n_q == '0) ? '0 : l;
			ow_q.box_min_y      <= (n_q == '0) ? '0 : t;
			ow_q.box_max_x      <= (n_q == '0) ? '0 : r;
			ow_q.box_max_y      <= (n_q == '0) ? '0 : b;
			ow_q.blob_valid     <= (n_q != '0);
			ow_q.table_overflow <= drop_q;
			ow_q.last_blob      <= (n_q == '0) || last_i;
		end
	end

endmodule

// ===== hdl/proximity_blob_bounding_boxes.sv =====
// A pixel enters the 4-word queue on acceptance and leaves it once the back part takes it.
// Back part: a dark pixel is taken in the idle state; a bright one is compared against
// each blob in turn until one matches (memory read + test), or goes straight to the test when the table is empty.
// Frame readout: a memory read state and an output state per reported box, one box per output word.
// Reset (arst_n low, async): table empty, overflow clear, registers to 60 and 64.
// The box store is not cleared; only entries below the fill count are read.
module proximity_blob_bounding_boxes #(
	parameter int MAX_BLOBS     = 64,
	parameter int FRAME_COLUMNS = 1024,
	parameter int FRAME_ROWS    = 1024
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  pbbb_pkg::pix_in_t            in_data,
	output logic                         out_valid,
	input  logic                         out_ready,
	output pbbb_pkg::blob_out_t          out_data,
	input  logic                         cfg_we,
	input  logic                         cfg_index,
	input  logic [pbbb_pkg::DistW-1:0]   cfg_data
);
	import pbbb_pkg::*;

	logic [7:0]       thresh_q;
	logic [DistW-1:0] dist_q;
	logic             job_valid, job_ready;
	job_t             job;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thresh_q <= ThreshReset;
			dist_q   <= DistReset;
		end else if (cfg_we) begin
			case (cfg_index)
				CfgThresh: thresh_q <= cfg_data[7:0];
				CfgDist:   dist_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	pbbb_front #(.FRAME_COLUMNS(FRAME_COLUMNS), .FRAME_ROWS(FRAME_ROWS)) u_front (
		.clk, .arst_n, .in_valid, .in_ready, .in_word(in_data), .thresh(thresh_q),
		.job_valid, .job_ready, .job
	);

	pbbb_back #(.MAX_BLOBS(MAX_BLOBS)) u_back (
		.clk, .arst_n, .job_valid, .job_ready, .job, .dist_lim(dist_q),
		.out_valid, .out_ready, .out_word(out_data)
	);

`ifndef SYNTH
	// Empty marker is always the last word of its readout
	a_last_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.blob_valid |-> out_data.last_blob)
		else $error("empty marker without last flag");
	a_empty_idx: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.blob_valid |-> out_data.blob_index == '0)
		else $error("empty marker with nonzero index");
	a_box_order: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.blob_valid |->
		out_data.box_min_x <= out_data.box_max_x && out_data.box_min_y <= out_data.box_max_y)
		else $error("inverted box");
`endif

endmodule

// ===== dv/proximity_blob_bounding_boxes_tb.sv =====
// Self-checking testbench for the proximity blob bounding box block.
module proximity_blob_bounding_boxes_tb;
	import pbbb_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NBLOBS = 64;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	pix_in_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	blob_out_t out_data;
	logic cfg_we = 1'b0;
	logic cfg_index = CfgThresh;
	logic [DistW-1:0] cfg_data = '0;

	proximity_blob_bounding_boxes uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #6 clk = ~clk;

	// Predictor state
	logic [7:0]       thresh_m;
	logic [DistW-1:0] dist_m;
	logic [9:0]       lft[NBLOBS], top_m[NBLOBS], rgt[NBLOBS], bot[NBLOBS];
	int               n_blobs;
	logic             dropped;

	blob_out_t boxes_due[$];
	int  mismatches = 0;
	bit  no_idle = 0;
	int  words_sent = 0;

	// Grow or create a blob for one pixel, and queue the readout on frame end
	task automatic predict_pixel(input pix_in_t p);
		logic [25:0] lim;
		logic [11:0] cx, cy, px, py, dx, dy;
		logic [25:0] d;
		bit hit;
		blob_out_t r;
		hit = 0;
		if (p.pixel_value > thresh_m) begin
			lim = {dist_m, 2'b00};
			px = {1'b0, p.pos_x, 1'b0};
			py = {1'b0, p.pos_y, 1'b0};
			for (int i = 0; i < n_blobs && !hit; i++) begin
				cx = lft[i] + rgt[i];
				cy = top_m[i] + bot[i];
				dx = (cx >= px) ? cx - px : px - cx;
				dy = (cy >= py) ? cy - py : py - cy;
				d = dx * dx + dy * dy;
				if (d < lim) begin
					hit = 1;
					if (p.pos_x < lft[i]) lft[i] = p.pos_x;
					if (p.pos_y < top_m[i]) top_m[i] = p.pos_y;
					if (p.pos_x > rgt[i]) rgt[i] = p.pos_x;
					if (p.pos_y > bot[i]) bot[i] = p.pos_y;
				end
			end
			if (!hit) begin
				if (n_blobs < NBLOBS) begin
					lft[n_blobs] = p.pos_x; rgt[n_blobs] = p.pos_x;
					top_m[n_blobs] = p.pos_y; bot[n_blobs] = p.pos_y;
					n_blobs++;
				end else
					dropped = 1;
			end
		end
		if (p.frame_end) begin
			if (n_blobs == 0) begin
				r = '0;
				r.table_overflow = dropped;
				r.last_blob = 1;
				boxes_due.push_back(r);
			end else
				for (int i = 0; i < n_blobs; i++) begin
					r.blob_index = 6'(i);
					r.box_min_x = lft[i]; r.box_min_y = top_m[i];
					r.box_max_x = rgt[i]; r.box_max_y = bot[i];
					r.blob_valid = 1;
					r.table_overflow = dropped;
					r.last_blob = (i == n_blobs - 1);
					boxes_due.push_back(r);
				end
			n_blobs = 0;
			dropped = 0;
		end
	endtask

	// Register write while idle
	task automatic write_reg(input logic idx, input logic [DistW-1:0] val);
		cfg_we <= 1; cfg_index <= idx; cfg_data <= val;
		@(posedge clk);
		cfg_we <= 0;
		@(posedge clk);
		if (idx == CfgThresh) thresh_m = val[7:0];
		else dist_m = val;
	endtask

	// Random gap before a word, unless idling is off
	task automatic maybe_gap();
		if (!no_idle && $urandom_range(0, 7) == 0) begin
			in_valid <= 0;
			repeat ($urandom_range(1, 18)) @(posedge clk);
		end
	endtask

	// Send one pixel word, predicting on acceptance; valid stays up for the next word
	task automatic send_pixel(input pix_in_t p);
		maybe_gap();
		in_valid <= 1; in_data <= p;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		predict_pixel(p);
		words_sent++;
	endtask

	task automatic drain();
		in_valid <= 0;
		while (boxes_due.size() != 0) @(posedge clk);
		// searches over a full table can still run after the last box
		repeat (300) @(posedge clk);
	endtask

	function automatic pix_in_t mk(input logic [7:0] v, input logic [9:0] x, y,
			input logic fe);
		pix_in_t p;
		p.pixel_value = v; p.pos_x = x; p.pos_y = y; p.frame_end = fe;
		return p;
	endfunction

	// Result receiver: random stall bursts, compares with oldest expected box
	initial begin
		blob_out_t e;
		int stall;
		stall = 0;
		forever begin
			@(posedge clk);
			if (out_valid && out_ready) begin
				if (boxes_due.size() == 0) begin
					mismatches++;
					if (mismatches <= 10) $display("unexpected box word %h", out_data);
				end else begin
					e = boxes_due.pop_front();
					if (out_data !== e) begin
						mismatches++;
						if (mismatches <= 10)
							$display("box mismatch: expected %h got %h", e, out_data);
					end
				end
			end
			if (stall > 0) stall--;
			else if (!no_idle && $urandom_range(0, 9) == 0) stall = $urandom_range(1, 18);
			out_ready <= (stall == 0);
		end
	end

	// Directed table: value, x, y, frame_end, expected single box (after reset)
	typedef struct {
		pix_in_t p;
		bit      chk;
		blob_out_t want;
	} row_t;

	initial begin
		row_t rows[$];
		row_t rw;
		pix_in_t p;
		int bx, by;
		thresh_m = ThreshReset; dist_m = DistReset; n_blobs = 0; dropped = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed rows; the empty frame's box is known at a glance
		rw.p = mk(8'd0, 10'd5, 10'd5, 1); rw.chk = 1;
		rw.want = '0; rw.want.last_blob = 1; rows.push_back(rw);
		rw.chk = 0;
		rw.p = mk(8'd61, 10'd0, 10'd0, 0); rows.push_back(rw);
		rw.p = mk(8'd60, 10'd900, 10'd900, 0); rows.push_back(rw);
		rw.p = mk(8'd255, 10'd3, 10'd2, 0); rows.push_back(rw);
		rw.p = mk(8'd255, 10'd1023, 10'd0, 0); rows.push_back(rw);
		rw.p = mk(8'd200, 10'd1020, 10'd5, 0); rows.push_back(rw);
		rw.p = mk(8'd255, 10'd1023, 10'd1023, 0); rows.push_back(rw);
		rw.p = mk(8'd128, 10'd0, 10'd1023, 1); rows.push_back(rw);
		rw.p = mk(8'd255, 10'd512, 10'd512, 1); rows.push_back(rw);
		foreach (rows[i]) begin
			if (rows[i].chk && boxes_due.size() == 0) begin
				predict_pixel(rows[i].p);
				boxes_due.pop_back();
				boxes_due.push_back(rows[i].want);
				in_valid <= 1; in_data <= rows[i].p;
				@(posedge clk);
				while (!in_ready) @(posedge clk);
				words_sent++;
			end else
				send_pixel(rows[i].p);
		end
		drain();

		// Table overflow: 66 spread blobs with zero merge distance
		write_reg(CfgDist, 22'd0);
		write_reg(CfgThresh, 22'd0);
		for (int i = 0; i < 66; i++)
			send_pixel(mk(8'd1, 10'(i * 15), 10'(i), i == 65));
		send_pixel(mk(8'd0, 10'd0, 10'd0, 1));
		drain();

		// Random frames under several settings
		for (int ph = 0; ph < 5; ph++) begin
			case (ph)
				0: begin write_reg(CfgThresh, 22'd60); write_reg(CfgDist, 22'd64); end
				1: begin write_reg(CfgThresh, 22'd255); write_reg(CfgDist, 22'd100); end
				2: begin write_reg(CfgThresh, 22'd128); write_reg(CfgDist, 22'h3FFFFF); end
				3: begin write_reg(CfgThresh, 22'(
					$urandom_range(0, 200))); write_reg(CfgDist, 22'(
					$urandom_range(0, 2000))); end
				default: begin write_reg(CfgThresh, 22'd30); write_reg(CfgDist, 22'd400);
					no_idle = 1; end
			endcase
			for (int f = 0; f < 4; f++) begin
				bx = $urandom_range(0, 1000); by = $urandom_range(0, 1000);
				for (int k = 0; k < 17; k++) begin
					p.pixel_value = 8'($urandom);
					if ($urandom_range(0, 5) == 0) begin
						p.pos_x = 10'($urandom); p.pos_y = 10'($urandom);
					end else begin
						p.pos_x = 10'(bx + $urandom_range(0, 23));
						p.pos_y = 10'(by + $urandom_range(0, 23));
					end
					p.frame_end = (k == 16) || ($urandom_range(0, 60) == 0);
					send_pixel(p);
				end
			end
			// pressure: hold off until all boxes are out
			if (ph == 1) begin
				in_valid <= 0;
				@(posedge clk);
				while (boxes_due.size() != 0) @(posedge clk);
			end
			drain();
		end

		if (mismatches == 0 && boxes_due.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	// Watchdog
	initial begin
		#20ms;
		$display("Simulation FAILED");
		$finish;
	end

endmodule
